### sv/hfa_pkg.sv
// Shared types and constants for the heap fit allocator search unit.
package hfa_pkg;

  localparam int unsigned MapEntriesDef = 512;
  localparam int unsigned IdxInW        = 9;
  localparam int unsigned ValW          = 4;
  localparam int unsigned SizeW         = 10;
  localparam int unsigned StartW        = 10;

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_NEXT  = 2'd1,
    STRAT_BEST  = 2'd2,
    STRAT_WORST = 2'd3
  } strat_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_ALLOC = 1'b1
  } action_e;

  // Control broadcast to every map cell.
  typedef struct packed {
    logic shift;
    logic wr;
    logic wr_bit;
  } cell_ctl_t;

endpackage

### sv/hfa_cell.sv
// One free-map cell: a single chunk bit in the rotating ring.
module hfa_cell
  import hfa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      sel_i,
  input  logic      shift_in_i,
  output logic      free_o
);

  logic free_q, free_d;

  always_comb begin
    free_d = free_q;
    if (ctl_i.wr && sel_i) begin
      free_d = ctl_i.wr_bit;
    end else if (ctl_i.shift) begin
      free_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 1'b1;
    end else begin
      free_q <= free_d;
    end
  end

  assign free_o = free_q;

endmodule

### sv/heap_fit_allocator_search_unit.sv
// Top level of the heap fit allocator search unit: cell ring plus scan control.
//
// The free map lives in a ring of MAP_ENTRIES one-bit cells (1 = chunk free,
// all free after reset). A write beat updates one cell and its result beat
// (start_plus_one 0, found 0) is ready in the next cycle. An allocate beat
// rotates the ring one chunk per cycle past a scan engine that watches cell
// 0; a full pass ends with an end-of-map step that closes the run that
// touches the end of the map, and the ring always completes its turn so the
// map ends where it began. First, best and worst fit take one pass; next fit
// takes two passes when the stored search point yields nothing. A request of
// zero chunks or more than the map skips the scan. The unit works on one item
// at a time; a new input beat is taken only while the unit is idle and the
// output register is empty or its beat is taken in that cycle. The strategy
// register (0 first, 1 next, 2 best, 3 worst fit) is written on the cfg
// channel, which is always ready, and must only be written while the unit is
// idle.
module heap_fit_allocator_search_unit
  import hfa_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = MapEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,      // strategy
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // entry_index[8:0], entry_value[12:9],
                                       // request_size[22:13], zero pad
  input  logic        s_axis_tuser_i,  // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // start_plus_one[9:0], zero pad
  output logic        m_axis_tuser_o   // found
);

  localparam int unsigned IdxW = $clog2(MAP_ENTRIES + 1);
  localparam int unsigned CW   = (IdxW > SizeW) ? IdxW : SizeW;
  localparam int unsigned Half = MAP_ENTRIES / 2;

  // Unpack the input beat.
  logic [IdxInW-1:0] entry_index;
  logic [ValW-1:0]   entry_value;
  logic [SizeW-1:0]  request_size;
  assign entry_index  = s_axis_tdata_i[IdxInW-1:0];
  assign entry_value  = s_axis_tdata_i[IdxInW+ValW-1:IdxInW];
  assign request_size = s_axis_tdata_i[IdxInW+ValW+SizeW-1:IdxInW+ValW];

  logic   in_fire, out_slot_free;
  state_e state_q, state_d;
  strat_e strat_q;

  logic [CW-1:0] i_q, i_d, run_q, run_d, s_q, s_d, start_q, start_d;
  logic [CW-1:0] pick_len_q, pick_len_d, pick_q, pick_d, sp_q, sp_d, n_q, n_d;
  logic          have_q, have_d, done_q, done_d, pass_q, pass_d;

  logic          out_valid_q, out_valid_d, out_found_q, out_found_d;
  logic [StartW-1:0] out_spo_q, out_spo_d;

  cell_ctl_t     ctl;
  logic [MAP_ENTRIES-1:0] cell_free;

  // Strategy register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strat_q <= STRAT_FIRST;
    end else if (cfg_valid_i) begin
      strat_q <= strat_e'(cfg_data_i);
    end
  end

  assign out_slot_free   = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_slot_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Cell ring: cell k takes its neighbor k+1, the last wraps to cell 0.
  for (genvar k = 0; k < MAP_ENTRIES; k++) begin : g_cell
    logic sel;
    assign sel = (CW'(entry_index) == CW'(k));
    hfa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .sel_i      (sel),
      .shift_in_i (cell_free[(k + 1) % MAP_ENTRIES]),
      .free_o     (cell_free[k])
    );
  end

  // Scan step signals.
  logic          in_map, is_free, req_ok, pass_end;
  logic [CW-1:0] from, run_inc;

  assign in_map  = (i_q < CW'(MAP_ENTRIES));
  assign is_free = in_map && cell_free[0];
  assign run_inc = run_q + CW'(1);
  assign from    = ((strat_q == STRAT_NEXT) && !pass_q) ? sp_q : '0;
  assign req_ok  = (request_size != '0) && (CW'(request_size) <= CW'(MAP_ENTRIES));
  assign pass_end = (state_q == ST_SCAN) && !in_map;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (s_axis_tuser_i == ACT_ALLOC)) begin
          state_d = req_ok ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (pass_end && !((strat_q == STRAT_NEXT) && !done_d && !pass_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    i_d = i_q; run_d = run_q; s_d = s_q; start_d = start_q;
    pick_len_d = pick_len_q; pick_d = pick_q; have_d = have_q;
    done_d = done_q; pass_d = pass_q; sp_d = sp_q; n_d = n_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_spo_d   = out_spo_q;
    out_found_d = out_found_q;
    ctl.shift  = 1'b0;
    ctl.wr     = 1'b0;
    ctl.wr_bit = (entry_value == '0);

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser_i == ACT_WRITE) begin
            ctl.wr      = 1'b1;
            out_valid_d = 1'b1;
            out_spo_d   = '0;
            out_found_d = 1'b0;
          end else begin
            i_d = '0; run_d = '0; s_d = '0; have_d = 1'b0;
            done_d = 1'b0; pass_d = 1'b0; n_d = CW'(request_size);
          end
        end
      end
      ST_SCAN: begin
        ctl.shift = in_map;
        i_d       = i_q + CW'(1);
        if (!done_q) begin
          if ((strat_q == STRAT_FIRST) || (strat_q == STRAT_NEXT)) begin
            if ((i_q < from) || !is_free) begin
              run_d = '0;
              s_d   = i_q + CW'(1);
            end else begin
              run_d = run_inc;
              if (run_inc >= n_q) begin
                done_d  = 1'b1;
                start_d = s_q;
              end
            end
          end else if (is_free) begin
            run_d = run_inc;
            if ((strat_q == STRAT_WORST) && (run_inc >= n_q) &&
                (run_inc >= CW'(Half))) begin
              done_d  = 1'b1;
              start_d = s_q;
            end
          end else begin
            if (run_q >= n_q) begin
              if ((strat_q == STRAT_BEST) && (run_q == n_q)) begin
                done_d  = 1'b1;
                start_d = s_q;
              end else if (!have_q ||
                           ((strat_q == STRAT_WORST) ? (run_q > pick_len_q)
                                                     : (run_q < pick_len_q))) begin
                have_d     = 1'b1;
                pick_len_d = run_q;
                pick_d     = s_q;
              end
            end
            run_d = '0;
            s_d   = i_q + CW'(1);
          end
        end
        if (pass_end) begin
          if ((strat_q == STRAT_NEXT) && !done_d && !pass_q) begin
            // Wrap once and search again from chunk 0.
            i_d = '0; run_d = '0; s_d = '0; pass_d = 1'b1;
          end else if ((strat_q == STRAT_NEXT) && done_d) begin
            sp_d = start_d + n_q;
          end
        end
      end
      ST_DONE: begin
        if (out_slot_free) begin
          out_valid_d = 1'b1;
          out_found_d = done_q || have_q;
          out_spo_d   = (done_q || have_q)
                        ? StartW'((done_q ? start_q : pick_q) + CW'(1)) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sp_q        <= '0;
      done_q      <= 1'b0;
      have_q      <= 1'b0;
      pass_q      <= 1'b0;
      i_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sp_q        <= sp_d;
      done_q      <= done_d;
      have_q      <= have_d;
      pass_q      <= pass_d;
      i_q         <= i_d;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    run_q      <= run_d;
    s_q        <= s_d;
    start_q    <= start_d;
    pick_len_q <= pick_len_d;
    pick_q     <= pick_d;
    n_q        <= n_d;
    out_spo_q  <= out_spo_d;
    out_found_q <= out_found_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(16 - StartW){1'b0}}, out_spo_q};
  assign m_axis_tuser_o  = out_found_q;

  // Scan index never runs past the end-of-map step.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (i_q <= CW'(MAP_ENTRIES)))
    else $error("scan index past end of map");

  // Every accepted beat leads to a pending result or an active search.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (out_valid_q || (state_q != ST_IDLE)))
    else $error("accepted beat dropped");

  // The ring rotates only while scanning.
  a_shift_scan_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.shift |-> (state_q == ST_SCAN))
    else $error("ring rotated outside a scan");

  // A search that leaves the scan has covered the full map.
  a_full_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && (state_d == ST_DONE)) |-> (i_q == CW'(MAP_ENTRIES)))
    else $error("scan ended before full ring turn");

endmodule
